@@ design/hbws_pkg.sv @@
// Shared types, constants and helper functions for the haptic burst sequencer.
// No dependencies; every design file imports this package.
`timescale 1ns / 1ps

package hbws_pkg;

   // Width of the saturating tick counters.
   localparam int TIME_BITS = 16;
   // Counter compares against 16-bit period fields run at the wider of the two.
   localparam int CMP_W     = (TIME_BITS > 16) ? TIME_BITS : 16;

   localparam logic [15:0] ZERO_CODE = 16'd32767;

   // Diagonal scale 0.707 as (amp * 707 + 500) / 1000.
   localparam logic [9:0] DIAG_NUM = 10'd707;
   localparam logic [9:0] DIAG_DEN = 10'd1000;
   localparam logic [9:0] DIAG_RND = 10'd500;

   localparam logic [7:0] RAMP_TICKS_RESET = 8'd18;
   localparam logic [7:0] HOLD_TICKS_RESET = 8'd7;

   // Shared multiply/divide unit sizing.
   localparam int DIV_W  = 25;
   localparam int DSR_W  = 10;
   localparam int DCNT_W = $clog2(DIV_W);

   // Item codes and register indexes.
   localparam logic       REQ_TICK    = 1'b0;
   localparam logic       REQ_COMMAND = 1'b1;
   localparam logic       CSR_RAMP_TICKS = 1'b0;
   localparam logic       CSR_HOLD_TICKS = 1'b1;
   localparam logic       PHASE_RAMP  = 1'b0;
   localparam logic       PHASE_HOLD  = 1'b1;

   // Direction codes of a command item.
   localparam logic [2:0] DIR_W  = 3'd0;
   localparam logic [2:0] DIR_E  = 3'd1;
   localparam logic [2:0] DIR_N  = 3'd2;
   localparam logic [2:0] DIR_S  = 3'd3;
   localparam logic [2:0] DIR_NW = 3'd4;
   localparam logic [2:0] DIR_NE = 3'd5;
   localparam logic [2:0] DIR_SW = 3'd6;
   localparam logic [2:0] DIR_SE = 3'd7;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_RENDER = 2'd1,
      MODE_PAUSE  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_READY,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } seq_state_type;

   typedef enum logic [1:0] {
      DRIVE_ZERO,
      DRIVE_PEAK,
      DRIVE_RAMP
   } drive_type;

   typedef struct packed {
      logic        req_type;
      logic [2:0]  direction;
      logic [14:0] amplitude;
      logic [7:0]  repeat_count;
      logic [15:0] render_ticks;
      logic [15:0] pause_ticks;
   } req_item_type;

   typedef struct packed {
      logic [15:0] dac_code_x;
      logic [15:0] dac_code_y;
      logic [1:0]  mode;
   } rsp_item_type;

   // Per-axis drive sign taken from the direction code.
   typedef struct packed {
      logic x_on;
      logic x_neg;
      logic y_on;
      logic y_neg;
      logic diag;
   } dir_type;

   function automatic dir_type dir_decode(input logic [2:0] code);
      dir_type d;
      unique case (code)
         DIR_W:   d = '{x_on: 1'b1, x_neg: 1'b0, y_on: 1'b0, y_neg: 1'b0, diag: 1'b0};
         DIR_E:   d = '{x_on: 1'b1, x_neg: 1'b1, y_on: 1'b0, y_neg: 1'b0, diag: 1'b0};
         DIR_N:   d = '{x_on: 1'b0, x_neg: 1'b0, y_on: 1'b1, y_neg: 1'b0, diag: 1'b0};
         DIR_S:   d = '{x_on: 1'b0, x_neg: 1'b0, y_on: 1'b1, y_neg: 1'b1, diag: 1'b0};
         DIR_NW:  d = '{x_on: 1'b1, x_neg: 1'b0, y_on: 1'b1, y_neg: 1'b0, diag: 1'b1};
         DIR_NE:  d = '{x_on: 1'b1, x_neg: 1'b1, y_on: 1'b1, y_neg: 1'b0, diag: 1'b1};
         DIR_SW:  d = '{x_on: 1'b1, x_neg: 1'b0, y_on: 1'b1, y_neg: 1'b1, diag: 1'b1};
         // southeast
         default: d = '{x_on: 1'b1, x_neg: 1'b1, y_on: 1'b1, y_neg: 1'b1, diag: 1'b1};
      endcase
      return d;
   endfunction

   // Bipolar DAC code: zero drive plus or minus (mag + adj).
   function automatic logic [15:0] axis_code(input logic on, input logic neg,
                                             input logic [14:0] mag, input logic adj);
      logic [15:0] m;
      m = {1'b0, mag} + {15'd0, adj};
      if (!on) begin
         return ZERO_CODE;
      end else if (neg) begin
         return ZERO_CODE - m;
      end else begin
         return ZERO_CODE + m;
      end
   endfunction

endpackage

@@ design/haptic_burst_waveform_sequencer_top.sv @@
// Two-axis vibrotactile burst sequencer: command/tick items in, DAC code items out.
// Depends on hbws_pkg; one shared multiply-then-restoring-divide unit.
`timescale 1ns / 1ps

// Steps: a tick outside the ramp phase goes through evaluate and the output register;
//   a ramp tick goes through evaluate, registered multiply, 25 one-bit steps of the
//   shared restoring divider, then the output register.
// One item at a time: the next item is taken only once the last one is through; a diagonal
//   command also runs the shared multiply and divide (divide by 1000), an axis-aligned
//   command does not; a stalled result holds the block in its output step.
// Reset (synchronous, active high): machine idle, counters and peaks zero,
//   ramp/hold registers back to 18 and 7, output register empty. No clearing pass.
module haptic_burst_waveform_sequencer_top
   import hbws_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // input item channel
   input  logic          req_valid,
   output logic          req_stall,
   input  req_item_type  req_item,
   // result item channel
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_item,
   // register write channel
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [7:0]    csr_wdata
);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   seq_state_type          state_ff, state_in;
   req_item_type           req_ff, req_in;

   logic [7:0]             ramp_ticks_ff, ramp_ticks_in;
   logic [7:0]             hold_ticks_ff, hold_ticks_in;

   mode_type               mode_ff, mode_in;
   logic                   pending_ff, pending_in;
   logic [7:0]             bursts_left_ff, bursts_left_in;
   logic [TIME_BITS-1:0]   mode_elapsed_ff, mode_elapsed_in;
   logic                   wave_phase_ff, wave_phase_in;
   logic [TIME_BITS-1:0]   wave_elapsed_ff, wave_elapsed_in;
   logic [14:0]            peak_mag_ff, peak_mag_in;
   dir_type                dir_ff, dir_in;
   logic [15:0]            burst_length_ff, burst_length_in;
   logic [15:0]            gap_length_ff, gap_length_in;

   // shared arithmetic unit operands and working registers
   drive_type              drive_ff, drive_in;
   logic                   diff_neg_ff, diff_neg_in;
   logic [14:0]            mul_a_ff, mul_a_in;
   logic [DSR_W-1:0]       mul_b_ff, mul_b_in;
   logic [DSR_W-1:0]       mul_add_ff, mul_add_in;
   logic [DSR_W-1:0]       divisor_ff, divisor_in;
   logic [DIV_W-1:0]       dvd_ff, dvd_in;
   logic [DSR_W-1:0]       rem_ff, rem_in;
   logic [DCNT_W-1:0]      cnt_ff, cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   // ------------------------------------------------------------------
   // Combinational helpers
   // ------------------------------------------------------------------
   logic                   req_accept;
   logic                   rsp_free;
   logic [TIME_BITS-1:0]   mode_inc;
   logic [TIME_BITS-1:0]   wave_inc;
   logic [9:0]             ramp_diff;
   logic [DSR_W:0]         rem_shift;
   dir_type                cmd_dir;
   logic                   rem_nz;
   logic                   x_neg_out;
   logic                   y_neg_out;
   logic [14:0]            out_mag;

   assign req_stall  = (state_ff != ST_READY);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   // saturating tick counters
   assign mode_inc = (&mode_elapsed_ff) ? mode_elapsed_ff : mode_elapsed_ff + 1'b1;
   assign wave_inc = (&wave_elapsed_ff) ? wave_elapsed_ff : wave_elapsed_ff + 1'b1;

   // R - 2t; only used in the ramp phase, where t <= R <= 255
   assign ramp_diff = {2'b00, ramp_ticks_ff} - {1'b0, wave_inc[7:0], 1'b0};

   // one restoring divider step
   assign rem_shift = {rem_ff, dvd_ff[DIV_W-1]};

   assign cmd_dir = dir_decode(req_ff.direction);
   assign rem_nz  = (rem_ff != '0);

   // output sign per axis: ramp flips with the sign of R - 2t
   assign x_neg_out = dir_ff.x_neg ^ ((drive_ff == DRIVE_RAMP) && diff_neg_ff);
   assign y_neg_out = dir_ff.y_neg ^ ((drive_ff == DRIVE_RAMP) && diff_neg_ff);
   assign out_mag   = (drive_ff == DRIVE_RAMP) ? dvd_ff[14:0] : peak_mag_ff;

   // ------------------------------------------------------------------
   // Sequencer: next state and datapath control
   // ------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      ramp_ticks_in   = ramp_ticks_ff;
      hold_ticks_in   = hold_ticks_ff;
      mode_in         = mode_ff;
      pending_in      = pending_ff;
      bursts_left_in  = bursts_left_ff;
      mode_elapsed_in = mode_elapsed_ff;
      wave_phase_in   = wave_phase_ff;
      wave_elapsed_in = wave_elapsed_ff;
      peak_mag_in     = peak_mag_ff;
      dir_in          = dir_ff;
      burst_length_in = burst_length_ff;
      gap_length_in   = gap_length_ff;
      drive_in        = drive_ff;
      diff_neg_in     = diff_neg_ff;
      mul_a_in        = mul_a_ff;
      mul_b_in        = mul_b_ff;
      mul_add_in      = mul_add_ff;
      divisor_in      = divisor_ff;
      dvd_in          = dvd_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_item_in     = rsp_item_ff;

      // drop the result once the far side takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register writes land at any time; the user is to send them only while idle, which the block does not enforce
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RAMP_TICKS: ramp_ticks_in = csr_wdata;
            CSR_HOLD_TICKS: hold_ticks_in = csr_wdata;
            default:        ramp_ticks_in = ramp_ticks_ff;
         endcase
      end

      unique case (state_ff)
         ST_READY: begin
            if (req_accept) begin
               req_in   = req_item;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (req_ff.req_type == REQ_COMMAND) begin
               // load the new burst; peaks replace the old ones at once
               dir_in          = cmd_dir;
               bursts_left_in  = req_ff.repeat_count;
               burst_length_in = req_ff.render_ticks;
               gap_length_in   = req_ff.pause_ticks;
               pending_in      = 1'b1;
               if (cmd_dir.diag) begin
                  // scale by 0.707 through the shared unit
                  mul_a_in   = req_ff.amplitude;
                  mul_b_in   = DIAG_NUM;
                  mul_add_in = DIAG_RND;
                  divisor_in = DIAG_DEN;
                  state_in   = ST_MUL;
               end else begin
                  peak_mag_in = req_ff.amplitude;
                  state_in    = ST_READY;
               end
            end else begin
               // tick: advance counters, then step the machine
               mode_elapsed_in = mode_inc;
               wave_elapsed_in = wave_inc;
               drive_in        = DRIVE_ZERO;
               unique case (mode_ff)
                  MODE_RENDER: begin
                     if (wave_phase_ff == PHASE_RAMP) begin
                        if (wave_inc > TIME_BITS'(ramp_ticks_ff)) begin
                           // ramp over: new phase starts at +peak
                           wave_phase_in   = PHASE_HOLD;
                           wave_elapsed_in = '0;
                           drive_in        = DRIVE_PEAK;
                        end else begin
                           drive_in = DRIVE_RAMP;
                        end
                     end else begin
                        if (wave_inc > TIME_BITS'(hold_ticks_ff)) begin
                           wave_phase_in   = PHASE_RAMP;
                           wave_elapsed_in = '0;
                        end
                        drive_in = DRIVE_PEAK;
                     end
                     if (CMP_W'(mode_inc) >= CMP_W'(burst_length_ff)) begin
                        if (bursts_left_ff <= 8'd1) begin
                           bursts_left_in = '0;
                           mode_in        = MODE_IDLE;
                        end else begin
                           bursts_left_in  = bursts_left_ff - 8'd1;
                           mode_in         = MODE_PAUSE;
                           mode_elapsed_in = '0;
                        end
                     end
                  end
                  MODE_PAUSE: begin
                     if (CMP_W'(mode_inc) >= CMP_W'(gap_length_ff)) begin
                        mode_in         = MODE_RENDER;
                        mode_elapsed_in = '0;
                     end
                  end
                  default: begin
                     mode_in = MODE_IDLE;
                     if (pending_ff) begin
                        pending_in      = 1'b0;
                        mode_in         = MODE_RENDER;
                        mode_elapsed_in = '0;
                     end
                  end
               endcase

               // ramp drive = floor(peak * (R - 2t) / R), done on magnitudes
               diff_neg_in = ramp_diff[9];
               mul_a_in    = peak_mag_ff;
               mul_b_in    = ramp_diff[9] ? DSR_W'(-ramp_diff) : DSR_W'(ramp_diff);
               mul_add_in  = '0;
               divisor_in  = DSR_W'(ramp_ticks_ff);
               if ((mode_ff == MODE_RENDER) && (wave_phase_ff == PHASE_RAMP)
                   && !(wave_inc > TIME_BITS'(ramp_ticks_ff))) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end

         ST_MUL: begin
            // registered product feeds the divider
            dvd_in   = DIV_W'(mul_a_ff) * DIV_W'(mul_b_ff) + DIV_W'(mul_add_ff);
            rem_in   = '0;
            cnt_in   = DCNT_W'(DIV_W - 1);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // one quotient bit per cycle
            if (rem_shift >= {1'b0, divisor_ff}) begin
               rem_in = DSR_W'(rem_shift - {1'b0, divisor_ff});
               dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DSR_W-1:0];
               dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (req_ff.req_type == REQ_COMMAND) begin
                  peak_mag_in = dvd_in[14:0];
                  state_in    = ST_READY;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end

         ST_OUT: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (drive_ff == DRIVE_ZERO) begin
                  rsp_item_in.dac_code_x = ZERO_CODE;
                  rsp_item_in.dac_code_y = ZERO_CODE;
               end else begin
                  // floor of a negative quotient rounds away from zero
                  rsp_item_in.dac_code_x = axis_code(dir_ff.x_on, x_neg_out, out_mag,
                     (drive_ff == DRIVE_RAMP) && x_neg_out && rem_nz);
                  rsp_item_in.dac_code_y = axis_code(dir_ff.y_on, y_neg_out, out_mag,
                     (drive_ff == DRIVE_RAMP) && y_neg_out && rem_nz);
               end
               rsp_item_in.mode = mode_ff;
               state_in         = ST_READY;
            end
         end

         default: state_in = ST_READY;
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_READY;
         ramp_ticks_ff   <= RAMP_TICKS_RESET;
         hold_ticks_ff   <= HOLD_TICKS_RESET;
         mode_ff         <= MODE_IDLE;
         pending_ff      <= 1'b0;
         bursts_left_ff  <= '0;
         mode_elapsed_ff <= '0;
         wave_phase_ff   <= PHASE_RAMP;
         wave_elapsed_ff <= '0;
         peak_mag_ff     <= '0;
         dir_ff          <= '0;
         burst_length_ff <= '0;
         gap_length_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ramp_ticks_ff   <= ramp_ticks_in;
         hold_ticks_ff   <= hold_ticks_in;
         mode_ff         <= mode_in;
         pending_ff      <= pending_in;
         bursts_left_ff  <= bursts_left_in;
         mode_elapsed_ff <= mode_elapsed_in;
         wave_phase_ff   <= wave_phase_in;
         wave_elapsed_ff <= wave_elapsed_in;
         peak_mag_ff     <= peak_mag_in;
         dir_ff          <= dir_in;
         burst_length_ff <= burst_length_in;
         gap_length_ff   <= gap_length_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Payload and arithmetic registers (no reset)
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      drive_ff    <= drive_in;
      diff_neg_ff <= diff_neg_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_add_ff  <= mul_add_in;
      divisor_ff  <= divisor_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

@@ design/hbws_checker.sv @@
// Port-level checks for the haptic burst sequencer, bound to the top level.
// Depends on hbws_pkg for the item types.
`timescale 1ns / 1ps

module hbws_checker
   import hbws_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input req_item_type  req_item,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input rsp_item_type  rsp_item
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous item still at work");

   // a command item never produces a result
   a_cmd_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_item.req_type == REQ_COMMAND)
      |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared after a command item");

   // reported mode is idle, render or pause
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.mode != 2'b11))
      else $error("invalid mode in result item");

endmodule

bind haptic_burst_waveform_sequencer_top hbws_checker u_hbws_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

@@ tb/tb_haptic_burst_waveform_sequencer_top.sv @@
// Self-checking testbench for the haptic burst sequencer: directed and random items,
// predicted DAC codes and machine modes compared field by field. Depends on hbws_pkg.
`timescale 1ns / 1ps

module tb_haptic_burst_waveform_sequencer_top;
   import hbws_pkg::*;

   localparam longint unsigned AGE_MAX = (64'd1 << TIME_BITS) - 1;
   // Longest internal path is a ramp tick through the shared divider; the drain wait covers it.
   localparam int DRAIN_CYCLES = 40;
   // Upper bound on ticks spent following one burst sequence
   localparam int SEQ_TICK_CAP = 120;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = CSR_RAMP_TICKS;
   logic [7:0]   csr_wdata = '0;

   haptic_burst_waveform_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Sequencer model: registers, burst machine and waveform state
   // ---------------------------------------------------------------------------
   logic [7:0]      ramp_len;
   logic [7:0]      hold_len;
   mode_type        cur_mode;
   bit              pending_start;
   logic [7:0]      bursts_left;
   longint unsigned mode_age;
   longint unsigned wave_age;
   logic            wave_phase_now;
   int              peak_x;
   int              peak_y;
   logic [15:0]     burst_len;
   logic [15:0]     gap_len;

   // Per-direction axis signs: W, E, N, S, NW, NE, SW, SE
   int x_sign [8] = '{1, -1, 0, 0, 1, -1, 1, -1};
   int y_sign [8] = '{0, 0, 1, -1, 1, 1, -1, -1};

   rsp_item_type expected_codes [$];

   int mismatches  = 0;
   int n_commands  = 0;
   int n_ticks     = 0;
   int n_checked   = 0;
   int n_writes    = 0;
   int idle_pct    = 0;
   int rsp_hold_left = 0;

   task automatic clear_model();
      ramp_len       = RAMP_TICKS_RESET;
      hold_len       = HOLD_TICKS_RESET;
      cur_mode       = MODE_IDLE;
      pending_start  = 1'b0;
      bursts_left    = '0;
      mode_age       = 0;
      wave_age       = 0;
      wave_phase_now = PHASE_RAMP;
      peak_x         = 0;
      peak_y         = 0;
      burst_len      = '0;
      gap_len        = '0;
   endtask

   function automatic longint unsigned age_step(longint unsigned a);
      return (a >= AGE_MAX) ? AGE_MAX : a + 1;
   endfunction

   // Ramp level floor(peak * (R - 2t) / R), rounding toward minus infinity
   function automatic int ramp_level(int peak, longint unsigned t);
      longint r, num, q;
      if (ramp_len == 0) return peak;
      r   = longint'(ramp_len);
      num = longint'(peak) * (r - 2 * longint'(t));
      q   = num / r;
      if ((num % r) != 0 && num < 0) q = q - 1;
      return int'(q);
   endfunction

   function automatic logic [15:0] dac_of(int drive);
      return 16'(int'(ZERO_CODE) + drive);
   endfunction

   // Command: load peaks, count and periods at once, and mark a burst pending
   function automatic void load_burst(req_item_type it);
      int mag;
      mag = int'(it.amplitude);
      if (it.direction >= DIR_NW)
         mag = (mag * int'(DIAG_NUM) + int'(DIAG_RND)) / int'(DIAG_DEN);
      peak_x        = x_sign[it.direction] * mag;
      peak_y        = y_sign[it.direction] * mag;
      bursts_left   = it.repeat_count;
      burst_len     = it.render_ticks;
      gap_len       = it.pause_ticks;
      pending_start = 1'b1;
   endfunction

   // Tick: step the machine and return the DAC codes it gives
   function automatic rsp_item_type advance_tick();
      rsp_item_type r;
      int dx, dy;
      dx = 0;
      dy = 0;
      mode_age = age_step(mode_age);
      wave_age = age_step(wave_age);
      case (cur_mode)
         MODE_RENDER: begin
            if (wave_phase_now == PHASE_RAMP) begin
               if (wave_age > ramp_len) begin
                  // ramp over: flip to hold and give its value at time zero
                  wave_phase_now = PHASE_HOLD;
                  wave_age       = 0;
                  dx = peak_x;
                  dy = peak_y;
               end else begin
                  dx = ramp_level(peak_x, wave_age);
                  dy = ramp_level(peak_y, wave_age);
               end
            end else begin
               if (wave_age > hold_len) begin
                  wave_phase_now = PHASE_RAMP;
                  wave_age       = 0;
               end
               dx = peak_x;
               dy = peak_y;
            end
            if (mode_age >= burst_len) begin
               if (bursts_left <= 1) begin
                  bursts_left = '0;
                  cur_mode    = MODE_IDLE;
               end else begin
                  bursts_left = bursts_left - 1;
                  cur_mode    = MODE_PAUSE;
                  mode_age    = 0;
               end
            end
         end
         MODE_PAUSE: begin
            if (mode_age >= gap_len) begin
               cur_mode = MODE_RENDER;
               mode_age = 0;
            end
         end
         default: begin
            cur_mode = MODE_IDLE;
            if (pending_start) begin
               pending_start = 1'b0;
               cur_mode      = MODE_RENDER;
               mode_age      = 0;
            end
         end
      endcase
      r.dac_code_x = dac_of(dx);
      r.dac_code_y = dac_of(dy);
      r.mode       = cur_mode;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random stall bursts and the checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         rsp_hold_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare every accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_codes.size() == 0) begin
            $error("result item with no prediction waiting: x %0d y %0d mode %0d",
                   rsp_item.dac_code_x, rsp_item.dac_code_y, rsp_item.mode);
            mismatches++;
         end else begin
            want = expected_codes.pop_front();
            check_field("dac_code_x", want.dac_code_x, rsp_item.dac_code_x);
            check_field("dac_code_y", want.dac_code_y, rsp_item.dac_code_y);
            check_field("mode", want.mode, rsp_item.mode);
            n_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------
   function automatic req_item_type rand_bits();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[$bits(req_item_type)-1:0];
   endfunction

   function automatic req_item_type make_cmd(logic [2:0] dir, logic [14:0] amp,
                                             logic [7:0] reps, logic [15:0] render,
                                             logic [15:0] pause);
      req_item_type it;
      it.req_type     = REQ_COMMAND;
      it.direction    = dir;
      it.amplitude    = amp;
      it.repeat_count = reps;
      it.render_ticks = render;
      it.pause_ticks  = pause;
      return it;
   endfunction

   // Random command; wild ones take every field over its full range
   function automatic req_item_type rand_command(bit wild);
      req_item_type it;
      it = rand_bits();
      it.req_type = REQ_COMMAND;
      if (!wild) begin
         case ($urandom_range(0, 5))
            0:       it.amplitude = '0;
            1:       it.amplitude = '1;
            default: ;
         endcase
         it.repeat_count = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
         it.render_ticks = 16'($urandom_range(0, 40));
         it.pause_ticks  = 16'($urandom_range(0, 12));
      end
      return it;
   endfunction

   // Present one item, hold it until accepted, then predict. Valid stays high on
   // return so a back-to-back item needs no second assignment in the same step.
   task automatic send_item(input req_item_type it);
      int gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.req_type == REQ_COMMAND) begin
         load_burst(it);
         n_commands++;
      end else begin
         expected_codes.push_back(advance_tick());
         n_ticks++;
      end
   endtask

   // Tick items carry junk in the unused fields
   task automatic send_tick();
      req_item_type it;
      it = rand_bits();
      it.req_type = REQ_TICK;
      send_item(it);
   endtask

   // Drop valid, wait for every predicted result, then let a trailing command finish
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      settle(DRAIN_CYCLES);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_RAMP_TICKS) ramp_len = value;
      else hold_len = value;
      n_writes++;
   endtask

   // Tick until the machine is idle with nothing pending, or the cap is hit
   task automatic run_out_burst(input int cap, input bit interrupt);
      int ticks;
      ticks = 0;
      while (ticks < cap && (cur_mode != MODE_IDLE || pending_start)) begin
         if (interrupt && $urandom_range(0, 39) == 0) begin
            send_item(rand_command($urandom_range(0, 1)));
         end else begin
            send_tick();
            ticks++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   task automatic test_idle_tick();
      // nothing pending after reset: zero drive, machine stays idle
      send_tick();
   endtask

   task automatic test_directions();
      logic [2:0]  dirs [7] = '{DIR_E, DIR_N, DIR_S, DIR_NW, DIR_NE, DIR_SW, DIR_SE};
      logic [14:0] amps [7] = '{15'h7FFF, 15'd1, 15'h7FFF, 15'h7FFF, 15'd1, 15'd0, 15'd16383};
      write_reg(CSR_RAMP_TICKS, 8'd2);
      write_reg(CSR_HOLD_TICKS, 8'd1);
      send_item(make_cmd(DIR_W, 15'h7FFF, 8'd1, 16'd200, 16'd0));
      send_tick();
      send_tick();
      // replace the peaks mid-burst and see each direction take effect at once
      foreach (dirs[i]) begin
         send_item(make_cmd(dirs[i], amps[i], 8'd1, 16'd200, 16'd0));
         send_tick();
      end
   endtask

   task automatic test_zero_ramp();
      // a zero ramp length ends the ramp on its first tick
      write_reg(CSR_RAMP_TICKS, 8'd0);
      repeat (3) send_tick();
   endtask

   task automatic test_repeat_and_replace();
      write_reg(CSR_RAMP_TICKS, 8'd4);
      write_reg(CSR_HOLD_TICKS, 8'd2);
      // longest periods and top count, then cut short by a fresh command
      send_item(make_cmd(DIR_SE, 15'd20000, 8'd255, 16'hFFFF, 16'hFFFF));
      send_tick();
      send_item(make_cmd(DIR_N, 15'd1000, 8'd3, 16'd2, 16'd1));
      run_out_burst(60, 1'b0);
   endtask

   // Mostly complete burst sequences with random content; the rest is noise
   task automatic test_random_bursts(input logic [7:0] ramp, input logic [7:0] hold,
                                     input int pct, input int count);
      int stop_at;
      write_reg(CSR_RAMP_TICKS, ramp);
      write_reg(CSR_HOLD_TICKS, hold);
      idle_pct = pct;
      stop_at  = n_commands + n_ticks + count;
      while (n_commands + n_ticks < stop_at) begin
         if ($urandom_range(0, 6) != 0) begin
            send_item(rand_command(1'b0));
            run_out_burst(SEQ_TICK_CAP, 1'b1);
         end else if ($urandom_range(0, 1) != 0) begin
            send_item(rand_command(1'b1));
         end else begin
            repeat ($urandom_range(1, 4)) send_tick();
         end
      end
   endtask

   initial begin
      clear_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_tick();
      test_directions();
      test_zero_ramp();
      test_repeat_and_replace();

      test_random_bursts(8'd1, 8'd1, 30, 195);
      test_random_bursts(8'd255, 8'd255, 20, 195);
      test_random_bursts(RAMP_TICKS_RESET, HOLD_TICKS_RESET, 0, 195);
      test_random_bursts(8'd3, 8'd2, 40, 195);
      test_random_bursts(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 25, 195);
      // closing stretch without idling on either side
      test_random_bursts(8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)), 0, 195);

      settle(DRAIN_CYCLES);
      $display("Sent %0d commands and %0d ticks over %0d register writes;",
               n_commands, n_ticks, n_writes);
      $display("checked %0d result items, %0d mismatches.", n_checked, mismatches);
      if (mismatches == 0 && expected_codes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #4000000;
      $display("Timeout with %0d result items outstanding", expected_codes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
